[src/bums_pkg.sv]
package bums_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int DATA_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH      = 32;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_EMIT   = 3'b100
  } sort_state_t;

  typedef struct packed {
    logic shift;   // move every held element one cell toward the output
    logic active;  // insertion wave may run
  } cell_ctl_t;

endpackage

[src/bums_cell.sv]
module bums_cell #(
  parameter int DATA_WIDTH = bums_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bums_pkg::cell_ctl_t   ctl,
  input  logic                  in_valid,
  input  logic [DATA_WIDTH-1:0] in_data,
  input  logic                  right_valid,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic                  held_valid,
  output logic [DATA_WIDTH-1:0] held_data,
  output logic                  pass_valid,
  output logic [DATA_WIDTH-1:0] pass_data
);
  import bums_pkg::*;

  logic in_smaller;

  assign in_smaller = $signed(in_data) < $signed(held_data);

  // Keep the smaller of held and incoming, hand the larger to the right.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      pass_valid <= 1'b0;
    end else if (ctl.shift) begin
      held_valid <= right_valid;
      held_data  <= right_data;
      pass_valid <= 1'b0;
    end else begin
      pass_valid <= 1'b0;
      if (ctl.active && in_valid) begin
        if (!held_valid) begin
          held_valid <= 1'b1;
          held_data  <= in_data;
        end else if (in_smaller) begin
          held_data  <= in_data;
          pass_valid <= 1'b1;
          pass_data  <= held_data;
        end else begin
          pass_valid <= 1'b1;
          pass_data  <= in_data;
        end
      end
    end
  end

endmodule

[src/bottom_up_merge_sort.sv]
// Sorter for a set of up to MAX_ELEMENTS signed values, ascending order.
// Load: one input transfer per cycle; each value ripples down a row of cells.
// After the last input the row settles, then emits one result per cycle while
// the sink is ready (m_axis_tready); results leave through a registered output.
// A new set is accepted once the last result has entered the output register.
// Reset (rst, synchronous, active high) empties the row, clears valid and overflow.
module bottom_up_merge_sort #(
  parameter int MAX_ELEMENTS = bums_pkg::MAX_ELEMENTS_DEF,
  parameter int DATA_WIDTH   = bums_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bums_pkg::VALUE_WIDTH-1:0]  s_axis_tdata,  // [31:0] value
  input  logic                              s_axis_tlast,  // is_last
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bums_pkg::VALUE_WIDTH-1:0]  m_axis_tdata,  // [31:0] sorted_value
  output logic                              m_axis_tlast,  // last_out
  output logic                              m_axis_tuser   // overflowed
);
  import bums_pkg::*;

  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  sort_state_t state;
  logic [CW-1:0] count;        // elements held in the row, then results left
  logic [CW-1:0] settle_cnt;
  logic          overflow_seen;

  logic                  held_valid [MAX_ELEMENTS];
  logic [DATA_WIDTH-1:0] held_data  [MAX_ELEMENTS];
  logic                  pass_valid [MAX_ELEMENTS];
  logic [DATA_WIDTH-1:0] pass_data  [MAX_ELEMENTS];

  cell_ctl_t ctl;
  logic      in_xfer;
  logic      store_en;
  logic      out_load;
  logic [DATA_WIDTH+VALUE_WIDTH-1:0] in_ext;
  logic [DATA_WIDTH+VALUE_WIDTH-1:0] out_ext;
  logic [DATA_WIDTH-1:0]             in_value;

  // Keep the low DATA_WIDTH bits of the input, zero-filled when wider.
  assign in_ext   = {{DATA_WIDTH{1'b0}}, s_axis_tdata};
  assign in_value = in_ext[DATA_WIDTH-1:0];
  assign out_ext  = {{VALUE_WIDTH{1'b0}}, held_data[0]};

  assign s_axis_tready = (state == ST_LOAD);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign store_en      = in_xfer && (count < CW'(MAX_ELEMENTS));

  // In the emit state, advance the output register whenever it is empty or being drained.
  assign out_load = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  assign ctl = '{shift: out_load, active: (state != ST_EMIT)};

  // Row of cells: cell 0 keeps the smallest value, larger ones move right.
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic                  c_in_valid;
    logic [DATA_WIDTH-1:0] c_in_data;
    logic                  c_right_valid;
    logic [DATA_WIDTH-1:0] c_right_data;

    if (i == 0) begin : g_head
      assign c_in_valid = store_en;
      assign c_in_data  = in_value;
    end else begin : g_body
      assign c_in_valid = pass_valid[i-1];
      assign c_in_data  = pass_data[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign c_right_valid = 1'b0;
      assign c_right_data  = '0;
    end else begin : g_mid
      assign c_right_valid = held_valid[i+1];
      assign c_right_data  = held_data[i+1];
    end

    bums_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .in_valid    (c_in_valid),
      .in_data     (c_in_data),
      .right_valid (c_right_valid),
      .right_data  (c_right_data),
      .held_valid  (held_valid[i]),
      .held_data   (held_data[i]),
      .pass_valid  (pass_valid[i]),
      .pass_data   (pass_data[i])
    );
  end

  // Sequencer: load the set, let the insertion waves settle, drain in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      count         <= '0;
      settle_cnt    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (store_en) begin
            count <= count + CW'(1);
          end else if (in_xfer) begin
            overflow_seen <= 1'b1;   // drop: row is full
          end
          if (in_xfer && s_axis_tlast) begin
            state      <= ST_SETTLE;
            settle_cnt <= '0;
          end
        end
        ST_SETTLE: begin
          settle_cnt <= settle_cnt + CW'(1);
          if (settle_cnt == CW'(MAX_ELEMENTS - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              state         <= ST_LOAD;
              overflow_seen <= 1'b0;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Output register: holds a result while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= out_ext[VALUE_WIDTH-1:0];
      m_axis_tlast <= (count == CW'(1));
      m_axis_tuser <= overflow_seen;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_emit_has_data: assert property (@(posedge clk) disable iff (rst)
    out_load |-> held_valid[0])
    else $error("emitting from an empty head cell");

  a_row_empty_after_set: assert property (@(posedge clk) disable iff (rst)
    (out_load && count == CW'(1)) |=> !held_valid[0])
    else $error("row not empty after last result");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (overflow_seen && state != ST_EMIT) |-> count == CW'(MAX_ELEMENTS))
    else $error("overflow flagged while row not full");

  a_settle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !pass_valid[MAX_ELEMENTS-1])
    else $error("value leaving the end of the row");

endmodule
